// ===== src/crcst_pkg.sv =====
// Shared types and constants for the CRC slice table entry generator.
// Used by crcst_stage, crc_slice_table_entry and crcst_chk; depends on nothing.
`timescale 1ns / 1ps

package crcst_pkg;

    localparam int CRC_WIDTH_DEF = 32;
    localparam int MAX_ROWS_DEF  = 8;

    localparam int ROW_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int POLY_W  = 32;
    localparam int ENTRY_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [POLY_W-1:0] POLY_RESET = 32'h04C1_1DB7;
    localparam logic              REFL_RESET = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLYNOMIAL = 1'b0,
        CFG_REFLECTED  = 1'b1
    } t_cfg_idx;

    // Control that travels with each beat down the pipeline
    typedef struct packed {
        logic             valid;
        logic             refl;
        logic [ROW_W-1:0] row;
    } t_stage_ctl;

endpackage

// ===== src/crcst_stage.sv =====
// One pipeline stage: eight CRC shift steps for one byte position, if active.
// Depends on crcst_pkg.
`timescale 1ns / 1ps

module crcst_stage
    import crcst_pkg::*;
#(
    parameter int CRC_WIDTH = CRC_WIDTH_DEF,
    parameter int STAGE_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_stage_ctl           i_up_ctl,
    input  logic [CRC_WIDTH-1:0] i_up_crc,
    output logic                 o_up_ready,
    input  logic [CRC_WIDTH-1:0] i_poly,
    output t_stage_ctl           o_dn_ctl,
    output logic [CRC_WIDTH-1:0] o_dn_crc,
    input  logic                 i_dn_ready
);

    localparam logic [ROW_W-1:0] STAGE_ROW = ROW_W'(STAGE_IDX);

    t_stage_ctl           r_ctl;
    logic [CRC_WIDTH-1:0] r_crc;
    logic [CRC_WIDTH-1:0] n_crc;
    logic                 w_active;

    // Take a new beat when empty or when the beat held here moves on
    assign o_up_ready = !r_ctl.valid || i_dn_ready;
    assign w_active   = (i_up_ctl.row >= STAGE_ROW);

    always_comb begin
        n_crc = i_up_crc;
        if (w_active) begin
            for (int k = 0; k < BYTE_W; k++) begin
                if (i_up_ctl.refl) begin
                    n_crc = (n_crc >> 1) ^ (n_crc[0] ? i_poly : '0);
                end else begin
                    n_crc = (n_crc << 1) ^ (n_crc[CRC_WIDTH-1] ? i_poly : '0);
                end
            end
        end
    end

    // Only the valid bit is reset; the payload follows it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (o_up_ready) begin
            r_ctl.valid <= i_up_ctl.valid;
        end
        if (o_up_ready) begin
            r_ctl.refl <= i_up_ctl.refl;
            r_ctl.row  <= i_up_ctl.row;
            r_crc      <= n_crc;
        end
    end

    assign o_dn_ctl = r_ctl;
    assign o_dn_crc = r_crc;

endmodule

// ===== src/crc_slice_table_entry.sv =====
// Top level of the CRC slice table entry generator: config registers, input
// stage and a chain of crcst_stage byte stages. Depends on crcst_pkg, crcst_stage.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// -------   ---------  ---------------------------  ------------------------------
// request   in         i_in_valid / o_in_stall      i_row, i_byte_index
// result    out        o_out_valid / i_out_stall    o_entry
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A request beat passes the input register and then MAX_ROWS byte stages to reach
// the result; each byte stage applies eight shift steps of the CRC register
// when active, so 8*(row+1) steps cover stages 1..row+1. Unless o_in_stall is high,
// one request beat may enter every cycle; the byte stage chain sets the depth.
// Reset is synchronous, active low, and empties every stage.
// A stall on the result side holds the last stage; bubbles further up still
// close, so o_in_stall rises only once every stage holds a beat.

module crc_slice_table_entry
    import crcst_pkg::*;
#(
    parameter int CRC_WIDTH = CRC_WIDTH_DEF,
    parameter int MAX_ROWS  = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ROW_W-1:0]     i_row,
    input  logic [BYTE_W-1:0]    i_byte_index,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ENTRY_W-1:0]   o_entry,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POLY_W-1:0]    i_cfg_data
);

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

    logic [POLY_W-1:0]    r_poly;
    logic                 r_refl;
    logic [CRC_WIDTH-1:0] w_poly;

    t_stage_ctl           w_ctl [0:MAX_ROWS];
    logic [CRC_WIDTH-1:0] w_crc [0:MAX_ROWS];
    logic                 w_rdy [0:MAX_ROWS+1];

    t_stage_ctl           r_s0_ctl;
    logic [CRC_WIDTH-1:0] r_s0_crc;
    t_stage_ctl           n_s0_ctl;
    logic [CRC_WIDTH-1:0] n_s0_crc;

    // ---------------------------------------------------------------------
    // Configuration registers; writes are always taken
    // ---------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RESET;
            r_refl <= REFL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POLYNOMIAL: r_poly <= i_cfg_data;
                CFG_REFLECTED:  r_refl <= i_cfg_data[0];
                default:        r_poly <= r_poly;
            endcase
        end
    end

    // Fit the polynomial to the CRC register: drop high bits or zero-extend
    assign w_poly = CRC_WIDTH'(r_poly);

    // ---------------------------------------------------------------------
    // Input stage: clamp the row and seed the CRC register with the byte
    // ---------------------------------------------------------------------
    always_comb begin
        n_s0_ctl.valid = i_in_valid;
        n_s0_ctl.refl  = r_refl;
        n_s0_ctl.row   = (i_row > ROW_LAST) ? ROW_LAST : i_row;
        if (r_refl) begin
            // reflected: byte enters at the low end
            n_s0_crc = CRC_WIDTH'(i_byte_index);
        end else begin
            // normal: byte enters in the top byte
            n_s0_crc = CRC_WIDTH'(i_byte_index) << (CRC_WIDTH - BYTE_W);
        end
    end

    assign w_rdy[0]   = !r_s0_ctl.valid || w_rdy[1];
    assign o_in_stall = !w_rdy[0];

    // Reset only the valid bit; advance the payload with it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl.valid <= 1'b0;
        end else if (w_rdy[0]) begin
            r_s0_ctl.valid <= n_s0_ctl.valid;
        end
        if (w_rdy[0]) begin
            r_s0_ctl.refl <= n_s0_ctl.refl;
            r_s0_ctl.row  <= n_s0_ctl.row;
            r_s0_crc      <= n_s0_crc;
        end
    end

    assign w_ctl[0] = r_s0_ctl;
    assign w_crc[0] = r_s0_crc;

    // ---------------------------------------------------------------------
    // Byte stages: stage k works the k-th byte position (k from 1), active
    // only while the clamped row reaches it; otherwise pass the word through
    // ---------------------------------------------------------------------
    for (genvar k = 1; k <= MAX_ROWS; k++) begin : g_stage
        crcst_stage #(
            .CRC_WIDTH (CRC_WIDTH),
            .STAGE_IDX (k - 1)
        ) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_up_ctl   (w_ctl[k-1]),
            .i_up_crc   (w_crc[k-1]),
            .o_up_ready (w_rdy[k]),
            .i_poly     (w_poly),
            .o_dn_ctl   (w_ctl[k]),
            .o_dn_crc   (w_crc[k]),
            .i_dn_ready (w_rdy[k+1])
        );
    end

    // ---------------------------------------------------------------------
    // Result: the last stage is the output register; hold it while stalled
    // ---------------------------------------------------------------------
    assign w_rdy[MAX_ROWS+1] = !i_out_stall;
    assign o_out_valid       = w_ctl[MAX_ROWS].valid;
    assign o_entry           = ENTRY_W'(w_crc[MAX_ROWS]);

endmodule

// ===== src/crcst_chk.sv =====
// Port-level checker for crc_slice_table_entry, attached by bind.
// Depends on crcst_pkg.
`timescale 1ns / 1ps

module crcst_chk
    import crcst_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [ENTRY_W-1:0] o_entry
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

    // Back-pressure reaches the request side only from a held result beat
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("request stalled without a held result beat");

    // A stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result beat dropped");

    // and keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_entry))
        else $error("stalled result payload changed");

endmodule

bind crc_slice_table_entry crcst_chk u_crcst_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_entry     (o_entry)
);
